FILE: rtl/core/bdma_pkg.sv
// package for the burnout detector moving-average block
// holds payload types, field widths and register indexes; no dependencies
package bdma_pkg;

   // field widths
   localparam int ACC_W     = 16;
   localparam int ALT_W     = 20;
   localparam int CSR_IDX_W = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MOTOR_OFF_ALT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ALT       = 2'd1;

   // reset value of both altitude thresholds
   localparam int ALT_THR_RESET = 524287;

   typedef struct packed {
      logic signed [ACC_W-1:0] accel_sample;
      logic signed [ALT_W-1:0] altitude_sample;
   } req_payload_type;

   typedef struct packed {
      logic                    motor_on;
      logic                    control_on;
      logic signed [ACC_W-1:0] mean_accel;
      logic signed [ALT_W-1:0] mean_altitude;
   } rsp_payload_type;

endpackage

FILE: rtl/core/bdma_window.sv
// sample window as a shift line with an exact running sum
// depends on nothing but its parameters
module bdma_window #(
   parameter int DATA_W = 16,
   parameter int WINDOW = 8,
   parameter int SUM_W  = DATA_W + $clog2(WINDOW)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     shift_en,
   input  logic signed [DATA_W-1:0] sample,
   output logic signed [SUM_W-1:0]  sum_next
);

   logic signed [DATA_W-1:0] taps_ff [WINDOW];
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;

   // oldest sample leaves, new sample enters
   always_comb begin
      sum_in = sum_ff + SUM_W'(sample) - SUM_W'(taps_ff[WINDOW-1]);
   end

   assign sum_next = sum_in;

   // shift line, oldest entry at the far end
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            taps_ff[i] <= '0;
         end
         sum_ff <= '0;
      end else if (shift_en) begin
         taps_ff[0] <= sample;
         for (int i = 1; i < WINDOW; i++) begin
            taps_ff[i] <= taps_ff[i-1];
         end
         sum_ff <= sum_in;
      end
   end

endmodule

FILE: rtl/core/bdma_mean_sat.sv
// mean from a window sum: arithmetic right shift, then saturation to the field
// depends on nothing but its parameters
module bdma_mean_sat #(
   parameter int SUM_W   = 19,
   parameter int FIELD_W = 16,
   parameter int SHIFT   = 3
) (
   input  logic signed [SUM_W-1:0]   sum,
   output logic signed [FIELD_W-1:0] mean
);

   logic signed [SUM_W-1:0]     shifted;
   logic        [SUM_W-FIELD_W:0] upper;

   // floor division by the window's power of two, clamp when out of range
   always_comb begin
      shifted = sum >>> SHIFT;
      upper   = shifted[SUM_W-1:FIELD_W-1];
      if ((&upper) || !(|upper)) begin
         mean = shifted[FIELD_W-1:0];
      end else if (shifted[SUM_W-1]) begin
         mean = {1'b1, {(FIELD_W-1){1'b0}}};
      end else begin
         mean = {1'b0, {(FIELD_W-1){1'b1}}};
      end
   end

endmodule

FILE: rtl/core/burnout_detect_moving_average_top.sv
// burnout detector: result valid in the cycle after request acceptance
// throughput one request per cycle; a stalled result holds off the next request
// window sums, flags and compares all complete between request and result register
// synchronous active-high reset clears windows, sums, flags and result valid,
// and loads both altitude thresholds with 524287
module burnout_detect_moving_average_top
   import bdma_pkg::*;
#(
   parameter int WINDOW = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ALT_W-1:0]     csr_wdata
);

   localparam int ACC_SUM_W = ACC_W + $clog2(WINDOW);
   localparam int ALT_SUM_W = ALT_W + $clog2(WINDOW);
   localparam int SHIFT     = $clog2(WINDOW + 1) - 1;
   localparam logic signed [ALT_SUM_W-1:0] THR_RESET =
      ALT_SUM_W'(ALT_THR_RESET * WINDOW);

   logic                        req_accept;
   logic signed [ACC_SUM_W-1:0] accel_sum;
   logic signed [ALT_SUM_W-1:0] altitude_sum;
   logic signed [ACC_W-1:0]     mean_accel;
   logic signed [ALT_W-1:0]     mean_altitude;

   logic signed [ALT_SUM_W-1:0] off_thr_ff;
   logic signed [ALT_SUM_W-1:0] min_thr_ff;
   logic signed [ALT_SUM_W-1:0] csr_ext;
   logic signed [ALT_SUM_W-1:0] csr_scaled;

   logic            motor_ff, motor_in, motor_set;
   logic            control_ff, control_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff;

   // handshake: the result register parts the two sides
   assign req_accept = req_valid && !req_stall;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign csr_ready  = 1'b1;

   // threshold writes are kept already scaled by the window length
   always_comb begin
      csr_ext    = ALT_SUM_W'($signed(csr_wdata));
      csr_scaled = ALT_SUM_W'(csr_ext * ALT_SUM_W'(WINDOW));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_thr_ff <= THR_RESET;
         min_thr_ff <= THR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MOTOR_OFF_ALT: off_thr_ff <= csr_scaled;
            CSR_MIN_ALT:       min_thr_ff <= csr_scaled;
            default:           ;
         endcase
      end
   end

   // sample windows
   bdma_window #(
      .DATA_W (ACC_W),
      .WINDOW (WINDOW),
      .SUM_W  (ACC_SUM_W)
   ) u_accel_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (req_accept),
      .sample   (req_payload.accel_sample),
      .sum_next (accel_sum)
   );

   bdma_window #(
      .DATA_W (ALT_W),
      .WINDOW (WINDOW),
      .SUM_W  (ALT_SUM_W)
   ) u_altitude_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (req_accept),
      .sample   (req_payload.altitude_sample),
      .sum_next (altitude_sum)
   );

   // means for the result
   bdma_mean_sat #(
      .SUM_W   (ACC_SUM_W),
      .FIELD_W (ACC_W),
      .SHIFT   (SHIFT)
   ) u_accel_mean (
      .sum  (accel_sum),
      .mean (mean_accel)
   );

   bdma_mean_sat #(
      .SUM_W   (ALT_SUM_W),
      .FIELD_W (ALT_W),
      .SHIFT   (SHIFT)
   ) u_altitude_mean (
      .sum  (altitude_sum),
      .mean (mean_altitude)
   );

   // motor set check, then burnout check which wins
   always_comb begin
      motor_set  = ((accel_sum > 0) && !motor_ff) || (altitude_sum >= min_thr_ff);
      motor_in   = motor_ff || motor_set;
      control_in = control_ff;
      if (((accel_sum < 0) && motor_in) || (altitude_sum >= off_thr_ff)) begin
         motor_in   = 1'b0;
         control_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motor_ff   <= 1'b0;
         control_ff <= 1'b0;
      end else if (req_accept) begin
         motor_ff   <= motor_in;
         control_ff <= control_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff.motor_on      <= motor_in;
         rsp_ff.control_on    <= control_in;
         rsp_ff.mean_accel    <= mean_accel;
         rsp_ff.mean_altitude <= mean_altitude;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // control flag never drops outside reset
   a_control_sticky: assert property (@(posedge clock) disable iff (reset)
      control_ff |=> control_ff)
      else $error("control flag cleared without reset");

   // an accepted request always leaves a result behind
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no result");

   // motor flag only falls on burnout, which enables control
   a_motor_off_control: assert property (@(posedge clock) disable iff (reset)
      ($fell(motor_ff) && !$past(reset)) |-> control_ff)
      else $error("motor flag cleared without control enable");

   // a pending result reflects the current control flag
   a_result_matches_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.control_on == control_ff))
      else $error("result control flag disagrees with state");

endmodule
